>>> design/c8lc_pkg.sv
package c8lc_pkg;

  localparam int LINE_MAX = 4096;
  localparam int POS_W    = $clog2(LINE_MAX);
  localparam int OUT_W    = 32;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  localparam logic [1:0] VERDICT_MATCH    = 2'd0;
  localparam logic [1:0] VERDICT_NO_CRC   = 2'd1;
  localparam logic [1:0] VERDICT_MISMATCH = 2'd2;
  localparam logic [1:0] VERDICT_EMPTY    = 2'd3;

  typedef struct packed {
    logic [7:0]       computed_crc;
    logic [7:0]       received_crc;
    logic [POS_W-1:0] payload_length;
    logic [1:0]       verdict;
  } c8lc_result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end
    return d[3:0];
  endfunction

  // MSB-first CRC-8 byte update, unrolled
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // strtol base 16 over two characters, wrapped to 8 bits
  function automatic logic [7:0] parse_suffix(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] s [2];
    logic [1:0] mode;   // 0 skip blanks, 1 digits, 2 stopped
    logic       neg;
    logic [7:0] v;
    s[0] = a;
    s[1] = b;
    mode = 2'd0;
    neg  = 1'b0;
    v    = 8'd0;
    for (int k = 0; k < 2; k++) begin
      if (mode == 2'd0) begin
        if (!is_ws(s[k])) begin
          if (s[k] == CHAR_PLUS || s[k] == CHAR_MINUS) begin
            neg  = (s[k] == CHAR_MINUS);
            mode = 2'd1;
          end else if (is_hex(s[k])) begin
            v    = {4'd0, hex_val(s[k])};
            mode = 2'd1;
          end else begin
            mode = 2'd2;
          end
        end
      end else if (mode == 2'd1) begin
        if (is_hex(s[k])) begin
          v = {v[3:0], hex_val(s[k])};
        end else begin
          mode = 2'd2;
        end
      end
    end
    return neg ? (8'd0 - v) : v;
  endfunction

endpackage

>>> design/c8lc_line.sv
module c8lc_line
  import c8lc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  output logic         res_valid,
  output c8lc_result_t res
);

  logic [7:0]       running_crc_r, running_crc_nxt;
  logic [7:0]       crc_at_star_r, crc_at_star_nxt;
  logic             star_seen_r, star_seen_nxt;
  logic             started_r, started_nxt;
  logic [POS_W-1:0] char_pos_r, char_pos_nxt;
  logic [POS_W-1:0] star_pos_r, star_pos_nxt;
  logic [POS_W-1:0] trim_end_r, trim_end_nxt;
  logic [7:0]       suffix_first_r, suffix_first_nxt;
  logic [7:0]       suffix_second_r, suffix_second_nxt;

  logic             is_nl;
  logic [POS_W:0]   star_p1, star_p2, pos_ext;
  logic [POS_W+1:0] star_p3;
  logic [7:0]       rx_val;

  assign is_nl   = (rx_byte == CHAR_NL);
  assign pos_ext = {1'b0, char_pos_r};
  assign star_p1 = {1'b0, star_pos_r} + (POS_W+1)'(1);
  assign star_p2 = {1'b0, star_pos_r} + (POS_W+1)'(2);
  assign star_p3 = {2'b00, star_pos_r} + (POS_W+2)'(3);
  assign rx_val  = parse_suffix(suffix_first_r, suffix_second_r);

  assign res_valid = step && is_nl;

  always_comb begin
    res = '0;
    if (trim_end_r == '0) begin
      res.verdict = VERDICT_EMPTY;
    end else if (star_seen_r && star_p3 <= {2'b00, trim_end_r}) begin
      res.received_crc   = rx_val;
      res.computed_crc   = crc_at_star_r;
      res.verdict        = (rx_val == crc_at_star_r) ? VERDICT_MATCH : VERDICT_MISMATCH;
      res.payload_length = star_pos_r;
    end else begin
      res.verdict        = VERDICT_NO_CRC;
      res.payload_length = trim_end_r;
      res.computed_crc   = star_seen_r ? crc_at_star_r : 8'd0;
    end
  end

  always_comb begin
    running_crc_nxt   = running_crc_r;
    crc_at_star_nxt   = crc_at_star_r;
    star_seen_nxt     = star_seen_r;
    started_nxt       = started_r;
    char_pos_nxt      = char_pos_r;
    star_pos_nxt      = star_pos_r;
    trim_end_nxt      = trim_end_r;
    suffix_first_nxt  = suffix_first_r;
    suffix_second_nxt = suffix_second_r;
    if (step) begin
      if (is_nl) begin
        running_crc_nxt   = '0;
        crc_at_star_nxt   = '0;
        star_seen_nxt     = 1'b0;
        started_nxt       = 1'b0;
        char_pos_nxt      = '0;
        star_pos_nxt      = '0;
        trim_end_nxt      = '0;
        suffix_first_nxt  = '0;
        suffix_second_nxt = '0;
      end else if (started_r || !is_ws(rx_byte)) begin
        started_nxt = 1'b1;
        if (char_pos_r < POS_LAST) begin
          if (star_seen_r && pos_ext == star_p1) begin
            suffix_first_nxt = rx_byte;
          end
          if (star_seen_r && pos_ext == star_p2) begin
            suffix_second_nxt = rx_byte;
          end
          if (rx_byte == CHAR_STAR) begin
            crc_at_star_nxt = running_crc_r;
            star_seen_nxt   = 1'b1;
            star_pos_nxt    = char_pos_r;
          end
          running_crc_nxt = crc8_byte(running_crc_r, rx_byte);
          if (!is_ws(rx_byte)) begin
            trim_end_nxt = char_pos_r + POS_W'(1);
          end
          char_pos_nxt = char_pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r   <= '0;
      crc_at_star_r   <= '0;
      star_seen_r     <= 1'b0;
      started_r       <= 1'b0;
      char_pos_r      <= '0;
      star_pos_r      <= '0;
      trim_end_r      <= '0;
      suffix_first_r  <= '0;
      suffix_second_r <= '0;
    end else begin
      running_crc_r   <= running_crc_nxt;
      crc_at_star_r   <= crc_at_star_nxt;
      star_seen_r     <= star_seen_nxt;
      started_r       <= started_nxt;
      char_pos_r      <= char_pos_nxt;
      star_pos_r      <= star_pos_nxt;
      trim_end_r      <= trim_end_nxt;
      suffix_first_r  <= suffix_first_nxt;
      suffix_second_r <= suffix_second_nxt;
    end
  end

endmodule

>>> design/crc8_line_checker.sv
// channel | dir | width | contents
// in_     | in  | 8     | rx_byte, one character per request
// out_    | out | 32    | one judgement per newline
//
// One character per cycle unless a stalled result holds a newline: input register,
// line state update, result register. A taken character enters the line state when
// it advances; a newline's result is registered at that edge and shows on out_.
// Reset (rst_n low, synchronous) clears the line state and both valid flags.
// A stalled result blocks the next newline and all input behind it, nothing else.
module crc8_line_checker
  import c8lc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [1:0] verdict, [13:2] payload_length,
                                       // [21:14] received_crc, [29:22] computed_crc
);

  logic         in_valid_r, in_valid_nxt;
  logic [7:0]   in_byte_r;
  logic         out_valid_r, out_valid_nxt;
  c8lc_result_t out_res_r;
  logic         advance;
  logic         res_valid;
  c8lc_result_t res;

  assign advance   = in_valid_r && ((in_byte_r != CHAR_NL) || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  c8lc_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - $bits(c8lc_result_t))'(0), out_res_r};

endmodule

>>> design/c8lc_checker.sv
module c8lc_checker
  import c8lc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [7:0]       in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [1:0] verdict;
  logic [7:0] rx_crc;
  logic [7:0] comp_crc;

  assign verdict  = out_tdata[1:0];
  assign rx_crc   = out_tdata[21:14];
  assign comp_crc = out_tdata[29:22];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && verdict == VERDICT_EMPTY |-> out_tdata[29:2] == '0)
    else $error("empty line with nonzero fields");

  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (verdict == VERDICT_MATCH || verdict == VERDICT_MISMATCH)
      |-> (rx_crc == comp_crc) == (verdict == VERDICT_MATCH))
    else $error("verdict disagrees with crc compare");

  a_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && verdict == VERDICT_NO_CRC |-> rx_crc == 8'd0 && out_tdata[13:2] != '0)
    else $error("unchecked line with received crc or zero length");

  // a plain character never blocks the request after it
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata != CHAR_NL |=> in_tready)
    else $error("input stalled after a character");

endmodule

bind crc8_line_checker c8lc_checker u_c8lc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
